// ===== rtl/sp2c_pkg.sv =====
// shared constants and types for the scan polar to cartesian converter
`default_nettype none

package sp2c_pkg;

    // default parameter values
    localparam int RANGE_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // result buffer depth, covers the pipeline fill plus some slack
    localparam int RESULT_DEPTH = 8;

    // fixed field widths
    localparam int RANGE_W = 16;
    localparam int CFG_W   = 16;
    localparam int COORD_W = 17;

    // quarter-wave sine polynomial coefficients
    localparam logic [11:0] POLY_C5 = 12'd2320;
    localparam logic [14:0] POLY_C3 = 15'd21024;
    localparam logic [15:0] POLY_C1 = 16'd51472;

    localparam logic [14:0]        SINE_MAX  = 15'h7FFF;
    localparam logic [31:0]        ROUND_ADD = 32'd16384;
    localparam logic [COORD_W-1:0] COORD_MAX = 17'd65535;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_MIN   = 2'd0,
        CFG_RANGE_MAX   = 2'd1,
        CFG_ANGLE_START = 2'd2,
        CFG_ANGLE_STEP  = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

// ===== rtl/scan_polar_to_cartesian.sv =====
// top level: range scanner samples to cartesian points
//
// usage:
//   s_axis carries one range sample per transfer; tuser flags the first
//   sample of a scan, which restarts the beam angle at angle_start. every
//   other sample takes the previous beam angle plus angle_step (wrapping).
//   samples outside the configured range band still advance the angle but
//   give no result; every other sample gives one point on m_axis.
//   the cfg channel writes one register per transfer (always ready); write
//   it only while no sample is in flight.
// path: the input transfer reaches m_axis_tvalid through the four-multiply
//   sine polynomial (one multiply per stage), the range scaling that writes
//   the result buffer and the registered output word.
// throughput: one sample per cycle, sustained while m_axis_tready is high.
// stall: the pipeline never stops; results wait in an 8-entry buffer ahead
//   of the output register, and s_axis_tready drops once eight points are
//   in flight or waiting.
// reset: config registers to their defaults, beam angle to zero, pipeline,
//   result buffer and output register emptied.
`default_nettype none

module scan_polar_to_cartesian #(
    parameter int RANGE_BITS = sp2c_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS = sp2c_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] range
    input  wire logic [0:0]  s_axis_tuser,   // [0] first_in_scan
    // point stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [16:0] point_x, [33:17] point_y, zero pad
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AB = ANGLE_BITS;
    localparam int N  = AB - 2;      // bits within a quadrant
    localparam int ZW = N + 1;       // quadrant position, 0 .. 2^N
    localparam int FD = sp2c_pkg::RESULT_DEPTH;
    localparam int PW = $clog2(FD);
    localparam int CW = sp2c_pkg::COORD_W;

    localparam logic [15:0] RMASK = (RANGE_BITS >= 16) ? 16'hFFFF :
                                    16'((32'd1 << RANGE_BITS) - 32'd1);
    localparam logic [ZW-1:0] ZFULL   = ZW'(1) << N;
    localparam logic [AB-1:0] QUARTER = AB'(1) << N;

    // configuration
    logic [15:0] r_band_lo;
    logic [15:0] r_band_hi;
    logic [15:0] r_angle_start;
    logic [15:0] r_angle_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_lo     <= '0;
            r_band_hi     <= 16'hFFFF;
            r_angle_start <= '0;
            r_angle_step  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sp2c_pkg::t_cfg_reg'(i_cfg_index))
                sp2c_pkg::CFG_RANGE_MIN:   r_band_lo     <= i_cfg_data;
                sp2c_pkg::CFG_RANGE_MAX:   r_band_hi     <= i_cfg_data;
                sp2c_pkg::CFG_ANGLE_START: r_angle_start <= i_cfg_data;
                sp2c_pkg::CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
            endcase
        end
    end

    // sign-extend the 16-bit angle registers, then wrap to AB bits
    logic [31:0]   w_start_wide;
    logic [31:0]   w_step_wide;
    logic [AB-1:0] w_start_ext;
    logic [AB-1:0] w_step_ext;

    assign w_start_wide = {{16{r_angle_start[15]}}, r_angle_start};
    assign w_step_wide  = {{16{r_angle_step[15]}}, r_angle_step};
    assign w_start_ext  = w_start_wide[AB-1:0];
    assign w_step_ext   = w_step_wide[AB-1:0];

    // input side: beam angle and band check at the transfer
    logic          w_in_xfer;
    logic [15:0]   w_range;
    logic          w_band_ok;
    logic [AB-1:0] w_angle;
    logic [AB-1:0] r_next_angle;
    logic [PW:0]   r_used;        // points in flight plus waiting

    assign s_axis_tready = (r_used < (PW+1)'(FD));
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_range       = s_axis_tdata & RMASK;
    assign w_band_ok     = (w_range >= r_band_lo) && (w_range <= r_band_hi);
    assign w_angle       = s_axis_tuser[0] ? w_start_ext : r_next_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_angle <= '0;
        end else if (w_in_xfer) begin
            r_next_angle <= w_angle + w_step_ext;
        end
    end

    // pipeline valids; only in-band samples travel
    logic r_v_s1, r_v_s2, r_v_s3, r_v_s4, r_v_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s1 <= 1'b0;
            r_v_s2 <= 1'b0;
            r_v_s3 <= 1'b0;
            r_v_s4 <= 1'b0;
            r_v_s5 <= 1'b0;
        end else begin
            r_v_s1 <= w_in_xfer && w_band_ok;
            r_v_s2 <= r_v_s1;
            r_v_s3 <= r_v_s2;
            r_v_s4 <= r_v_s3;
            r_v_s5 <= r_v_s4;
        end
    end

    // payload; lane 0 is cosine (x), lane 1 is sine (y)
    logic [15:0]   r_rng_s1, r_rng_s2, r_rng_s3, r_rng_s4, r_rng_s5;
    logic [AB-1:0] r_ang_s1;

    logic [AB-1:0]    w_lane_ang [2];
    logic [ZW-1:0]    w_z        [2];
    logic [2*ZW-1:0]  w_zz       [2];
    logic [12+ZW-1:0] w_p5       [2];
    logic [14:0]      w_d3       [2];
    logic [15+ZW-1:0] w_p3       [2];
    logic [15:0]      w_d1       [2];
    logic [16+ZW-1:0] w_p1       [2];
    logic [15:0]      w_t3       [2];
    logic [31:0]      w_prod     [2];
    logic [CW-1:0]    w_mag      [2];
    logic [CW-1:0]    w_mag_sat  [2];
    logic [CW-1:0]    w_coord    [2];

    logic [ZW-1:0] r_z_s2 [2], r_z_s3 [2], r_z_s4 [2];
    logic [ZW-1:0] r_zsq_s2 [2], r_zsq_s3 [2];
    logic [11:0]   r_t1_s3 [2];
    logic [14:0]   r_t2_s4 [2];
    logic [14:0]   r_sin_s5 [2];
    logic          r_neg_s2 [2], r_neg_s3 [2], r_neg_s4 [2], r_neg_s5 [2];

    assign w_lane_ang[0] = r_ang_s1 + QUARTER;
    assign w_lane_ang[1] = r_ang_s1;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // fold the angle into the first quadrant
            w_z[l] = w_lane_ang[l][N] ? (ZFULL - {1'b0, w_lane_ang[l][N-1:0]})
                                      : {1'b0, w_lane_ang[l][N-1:0]};
            w_zz[l] = w_z[l] * w_z[l];
            w_p5[l] = sp2c_pkg::POLY_C5 * r_zsq_s2[l];
            w_d3[l] = sp2c_pkg::POLY_C3 - {3'b000, r_t1_s3[l]};
            w_p3[l] = w_d3[l] * r_zsq_s3[l];
            w_d1[l] = sp2c_pkg::POLY_C1 - {1'b0, r_t2_s4[l]};
            w_p1[l] = r_z_s4[l] * w_d1[l];
            w_t3[l] = w_p1[l][N+15:N];
            // scale by range, round half away from zero on the magnitude
            w_prod[l]    = 32'(r_rng_s5) * 32'(r_sin_s5[l]) + sp2c_pkg::ROUND_ADD;
            w_mag[l]     = w_prod[l][31:15];
            w_mag_sat[l] = (w_mag[l] > sp2c_pkg::COORD_MAX) ? sp2c_pkg::COORD_MAX
                                                             : w_mag[l];
            w_coord[l]   = r_neg_s5[l] ? (CW'(0) - w_mag_sat[l]) : w_mag_sat[l];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rng_s1 <= w_range;
        r_ang_s1 <= w_angle;
        r_rng_s2 <= r_rng_s1;
        r_rng_s3 <= r_rng_s2;
        r_rng_s4 <= r_rng_s3;
        r_rng_s5 <= r_rng_s4;
        for (int l = 0; l < 2; l++) begin
            // stage 2: fold and square
            r_z_s2[l]   <= w_z[l];
            r_neg_s2[l] <= w_lane_ang[l][AB-1];
            r_zsq_s2[l] <= w_zz[l][N+ZW-1:N];
            // stage 3: fifth-order term
            r_z_s3[l]   <= r_z_s2[l];
            r_zsq_s3[l] <= r_zsq_s2[l];
            r_neg_s3[l] <= r_neg_s2[l];
            r_t1_s3[l]  <= w_p5[l][N+11:N];
            // stage 4: third-order term
            r_z_s4[l]   <= r_z_s3[l];
            r_neg_s4[l] <= r_neg_s3[l];
            r_t2_s4[l]  <= w_p3[l][N+14:N];
            // stage 5: linear term and clamp at one
            r_neg_s5[l] <= r_neg_s4[l];
            r_sin_s5[l] <= (w_t3[l] > {1'b0, sp2c_pkg::SINE_MAX}) ? sp2c_pkg::SINE_MAX
                                                                  : w_t3[l][14:0];
        end
    end

    // result buffer, drained through a registered output word
    logic [2*CW-1:0] r_fifo [FD];
    logic [PW:0]     r_wr_ptr;
    logic [PW:0]     r_rd_ptr;
    logic [PW:0]     w_fifo_cnt;
    logic            r_out_valid;
    logic [2*CW-1:0] r_out_data;
    logic            w_out_xfer;
    logic            w_load;

    assign w_fifo_cnt    = r_wr_ptr - r_rd_ptr;
    assign w_out_xfer    = r_out_valid && m_axis_tready;
    // refill the output word when it is empty or leaving this cycle
    assign w_load        = (w_fifo_cnt != '0) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_data};

    always_ff @(posedge i_clk) begin
        if (r_v_s5) begin
            r_fifo[r_wr_ptr[PW-1:0]] <= {w_coord[1], w_coord[0]};
        end
        if (w_load) begin
            r_out_data <= r_fifo[r_rd_ptr[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_v_s5) begin
                r_wr_ptr <= r_wr_ptr + (PW+1)'(1);
            end
            if (w_load) begin
                r_rd_ptr <= r_rd_ptr + (PW+1)'(1);
            end
            priority if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
            // credit: taken by an in-band sample, returned when its point leaves
            priority if ((w_in_xfer && w_band_ok) && !w_out_xfer) begin
                r_used <= r_used + (PW+1)'(1);
            end else if (!(w_in_xfer && w_band_ok) && w_out_xfer) begin
                r_used <= r_used - (PW+1)'(1);
            end else begin
                r_used <= r_used;
            end
        end
    end

    // checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (PW+1)'(FD))
        else $error("credit count above buffer depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_s5 |-> (w_fifo_cnt < (PW+1)'(FD)))
        else $error("result buffer written while full");

    a_credit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((PW+1)'($countones({r_v_s1, r_v_s2, r_v_s3, r_v_s4, r_v_s5})) + w_fifo_cnt
            + {{PW{1'b0}}, r_out_valid}) == r_used)
        else $error("credit count disagrees with points in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("point changed while stalled");

    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && s_axis_tuser[0]) |=> (r_ang_s1 == $past(w_start_ext)))
        else $error("first sample of a scan did not take the start angle");

endmodule

`default_nettype wire

// ===== tb/sv/scan_point_checker.sv =====
// watches the sample, point and register channels and checks every point
`timescale 1ns / 1ps

module scan_point_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] range
    input  wire logic [0:0]  s_axis_tuser,   // [0] first_in_scan
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // [16:0] point_x, [33:17] point_y, zero pad
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_points_due,
    output int               o_fail_count
);

    localparam int QUAD_BITS   = 14;
    localparam int PRINT_LIMIT = 100;
    localparam int COORD_W     = sp2c_pkg::COORD_W;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_point;

    // own copy of the register file and the running beam angle
    logic [15:0] band_lo;
    logic [15:0] band_hi;
    logic [15:0] start_angle;
    logic [15:0] angle_inc;
    logic [15:0] beam_angle;
    logic [15:0] used_angle;
    logic [15:0] sample_range;
    t_point      pending_points[$];
    t_point      want_point;
    t_point      got_point;
    int          mismatch_count;

    // quarter-wave sine magnitude in Q1.15, z is the position in the quadrant
    function automatic logic [15:0] quarter_wave_sine(input logic [14:0] z);
        logic [63:0] z2;
        logic [63:0] acc;
        z2  = (64'(z) * 64'(z)) >> QUAD_BITS;
        acc = (64'd2320 * z2) >> QUAD_BITS;
        acc = 64'd21024 - acc;
        acc = (acc * z2) >> QUAD_BITS;
        acc = 64'd51472 - acc;
        acc = (64'(z) * acc) >> QUAD_BITS;
        return (acc > 64'd32767) ? 16'd32767 : acc[15:0];
    endfunction

    // range times sine of the angle, rounded half away from zero, saturated
    function automatic logic [COORD_W-1:0] coord_of_beam(input logic [15:0] r,
                                                         input logic [15:0] a);
        logic [1:0]         quad;
        logic [14:0]        z;
        logic [63:0]        mag;
        logic [COORD_W-1:0] mag17;
        quad = a[15:14];
        z    = quad[0] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        mag  = (64'(r) * 64'(quarter_wave_sine(z)) + 64'd16384) >> 15;
        if (mag > 64'd65535) begin
            mag = 64'd65535;
        end
        mag17 = mag[COORD_W-1:0];
        return quad[1] ? (17'd0 - mag17) : mag17;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            band_lo     = 16'd0;
            band_hi     = 16'hFFFF;
            start_angle = 16'd0;
            angle_inc   = 16'd0;
            beam_angle  = 16'd0;
            pending_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sp2c_pkg::CFG_RANGE_MIN:   band_lo     = i_cfg_data;
                    sp2c_pkg::CFG_RANGE_MAX:   band_hi     = i_cfg_data;
                    sp2c_pkg::CFG_ANGLE_START: start_angle = i_cfg_data;
                    sp2c_pkg::CFG_ANGLE_STEP:  angle_inc   = i_cfg_data;
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got_point = m_axis_tdata[2*COORD_W-1:0];
                if (pending_points.size() == 0) begin
                    report_mismatch($sformatf("point x=%0d y=%0d with none expected",
                        $signed(got_point.x), $signed(got_point.y)));
                end else begin
                    want_point = pending_points.pop_front();
                    if (got_point.x !== want_point.x) begin
                        report_mismatch($sformatf("point_x got %0d expected %0d",
                            $signed(got_point.x), $signed(want_point.x)));
                    end
                    if (got_point.y !== want_point.y) begin
                        report_mismatch($sformatf("point_y got %0d expected %0d",
                            $signed(got_point.y), $signed(want_point.y)));
                    end
                    if (m_axis_tdata[39:2*COORD_W] !== '0) begin
                        report_mismatch($sformatf("tdata pad got %h",
                            m_axis_tdata[39:2*COORD_W]));
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                sample_range = s_axis_tdata;
                used_angle   = s_axis_tuser[0] ? start_angle : beam_angle;
                beam_angle   = used_angle + angle_inc;
                if (sample_range >= band_lo && sample_range <= band_hi) begin
                    want_point.x = coord_of_beam(sample_range, used_angle + 16'h4000);
                    want_point.y = coord_of_beam(sample_range, used_angle);
                    pending_points.insert(pending_points.size(), want_point);
                end
            end
        end
        o_points_due = pending_points.size();
        // a point still owed at the end counts as a failure too
        o_fail_count = mismatch_count + o_points_due;
    end

endmodule

// ===== tb/sv/scan_polar_to_cartesian_test.sv =====
// stimulus and verdict for the scan polar to cartesian converter
`timescale 1ns / 1ps

module scan_polar_to_cartesian_test;

    // about 1900 samples in all, even under the heaviest receiver stalls;
    // the limit leaves a wide margin above the run time that these need
    localparam int RUN_LIMIT     = 400000;
    // samples outside the band leave no trace that the checker counts
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 240;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] range
    logic [0:0]  s_axis_tuser  = '0;    // [0] first_in_scan
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [39:0] m_axis_tdata;          // [16:0] point_x, [33:17] point_y, zero pad
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;

    int          points_due;
    int          fail_count;
    int          cycle_count   = 0;
    logic [31:0] stall_tick    = '0;
    int          burst_left    = 0;

    // current band, kept here so that random ranges can aim at its edges
    logic [15:0] band_lo = 16'd0;
    logic [15:0] band_hi = 16'hFFFF;

    scan_polar_to_cartesian uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    scan_point_checker u_point_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_points_due  (points_due),
        .o_fail_count  (fail_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver back-pressure: four patterns in turn, chosen by the tick count -
    // always ready, coin toss, stalled when the tick is a multiple of three, mostly stalled
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[10:9])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_axis_tready <= (stall_tick % 3) != 0;
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // one sample transfer; called and returning at a falling edge. the sender
    // runs in bursts with idle gaps between them, and tvalid stays high
    // across back-to-back samples within a burst
    task automatic send_sample(input logic [15:0] range_val, input logic first_flag);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= range_val;
        s_axis_tuser[0] <= first_flag;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // drop tvalid and wait until every owed point has come out, then give
    // samples that fall outside the band time to leave the pipeline
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (points_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register transfer; i_cfg_valid is left high for the next one
    task automatic put_reg(input sp2c_pkg::t_cfg_reg idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] lo, input logic [15:0] hi,
                                  input logic [15:0] start, input logic [15:0] step);
        put_reg(sp2c_pkg::CFG_RANGE_MIN, lo);
        put_reg(sp2c_pkg::CFG_RANGE_MAX, hi);
        put_reg(sp2c_pkg::CFG_ANGLE_START, start);
        put_reg(sp2c_pkg::CFG_ANGLE_STEP, step);
        i_cfg_valid <= 1'b0;
        band_lo = lo;
        band_hi = hi;
    endtask

    // mostly full-width random ranges, the rest on and beside the band edges or at the range extremes
    function automatic logic [15:0] pick_range();
        logic [15:0] r;
        case ($urandom_range(0, 9))
            6:       r = band_lo;
            7:       r = band_hi;
            8:       r = $urandom_range(0, 1) ? band_lo - 16'd1 : band_hi + 16'd1;
            9:       r = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    // one scan: a first sample, then a run that now and then restarts early
    task automatic run_scan(input int len);
        send_sample(pick_range(), 1'b1);
        for (int k = 1; k < len; k++) begin
            send_sample(pick_range(), $urandom_range(0, 19) == 0);
        end
    endtask

    // random register settings for one phase
    task automatic pick_settings();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] step;
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 4))
            0: begin lo = 16'd0; hi = 16'hFFFF; end
            1: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
            2: begin
                lo = a;
                hi = (a > 16'hFF00) ? 16'hFFFF : a + 16'($urandom_range(0, 255));
            end
            3: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end  // empty band unless a equals b
            default: begin
                lo = 16'($urandom_range(0, 4095));
                hi = 16'($urandom_range(40000, 65535));
            end
        endcase
        case ($urandom_range(0, 4))
            0:       step = 16'h7FFF;
            1:       step = 16'h8000;
            2:       step = 16'($urandom_range(0, 2047)) - 16'd1024;
            default: step = 16'($urandom);
        endcase
        apply_settings(lo, hi, 16'($urandom), step);
    endtask

    initial begin
        int sent;
        int len;

        // synchronous reset, released at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: full band, angle held at zero, range extremes
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // quarter-turn steps land exactly on the quadrant edges, where the
        // sine reaches one and gets clamped; full range for the largest values
        wait_idle();
        apply_settings(16'd0, 16'hFFFF, 16'h4000, 16'h4000);
        send_sample(16'hFFFF, 1'b1);
        repeat (4) send_sample(16'hFFFF, 1'b0);

        // most negative start with a step of minus one, angle wraps downward
        wait_idle();
        apply_settings(16'd0, 16'hFFFF, 16'h8000, 16'hFFFF);
        send_sample(16'd1234, 1'b1);
        send_sample(16'd40000, 1'b0);
        send_sample(16'hFFFF, 1'b0);

        // empty band: minimum above maximum, nothing may come out
        wait_idle();
        apply_settings(16'd100, 16'd50, 16'h7FFF, 16'h7FFF);
        send_sample(16'd75, 1'b1);
        send_sample(16'd100, 1'b0);
        send_sample(16'd50, 1'b0);

        // single-value band, with the samples just outside it
        wait_idle();
        apply_settings(16'd1000, 16'd1000, 16'h0001, 16'h8000);
        send_sample(16'd999, 1'b1);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd1001, 1'b0);
        send_sample(16'd1000, 1'b0);

        // random phases, each under its own settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            pick_settings();
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 60);
                if (len > PHASE_SAMPLES - sent) begin
                    len = PHASE_SAMPLES - sent;
                end
                run_scan(len);
                sent += len;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (points_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
